### rtl/core/ilc_pkg.sv
// ----------------------------------------------------------------------------
// ilc_pkg: shared types and constants of the interlace comb pixel block
// Holds the payload structs, the configuration bundle, the command that the
// front passes to the back, and the register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ilc_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WEFF_W    = ADDR_W + 1;

  // Configuration register limits and the blend rounding constant.
  localparam int SHIFT_LIMIT = 40;
  localparam int BAND_LIMIT  = 4;
  localparam int Q8_ONE      = 256;
  localparam int ROUND_HALF  = 32768;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_PIXELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_ROWS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DARKEN_AMOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_AMOUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_ENABLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PARITY  = 3'd6;

  // One input pixel.
  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic [7:0] pix_alpha;
    logic       start_of_frame;
  } in_pix_t;

  // One result pixel.
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [11:0] out_column;
    logic        last_of_run;
  } out_pix_t;

  // Effective configuration, already saturated and wrapped.
  typedef struct packed {
    logic [WEFF_W-1:0] w_eff;
    logic [5:0]        s_eff;
    logic [2:0]        b_eff;
    logic [8:0]        keep;
    logic [8:0]        mix;
    logic              phase;
    logic              busy;
  } cfg_t;

  // A run of outputs: first column, count minus one, and field.
  typedef struct packed {
    logic [ADDR_W-1:0] x;
    logic [5:0]        cnt;
    logic              odd;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/ilc_ram.sv
// ----------------------------------------------------------------------------
// ilc_ram: generic line store RAM
// One write port and two read ports, with registered read data that holds
// while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ilc_cfg.sv
// ----------------------------------------------------------------------------
// ilc_cfg: configuration registers
// Holds the raw registers, saturates them, and wraps the shift into the row
// width by repeated subtraction after each write.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_cfg
  import ilc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [12:0] row_width_q;
  logic [5:0]  shift_pixels_q;
  logic [2:0]  band_rows_q;
  logic [8:0]  darken_q;
  logic [8:0]  mix_q;
  logic        motion_q;
  logic        parity_q;

  logic        reload_q, reload_d;
  logic [5:0]  s_rem_q, s_rem_d;

  logic [WEFF_W-1:0] w_eff;
  logic [5:0]        s_sat;
  logic [2:0]        b_eff;
  logic [WEFF_W-1:0] s_rem_ext;
  logic              wrap_pending;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= 13'd1920;
      shift_pixels_q <= 6'd6;
      band_rows_q    <= 3'd1;
      darken_q       <= 9'd77;
      mix_q          <= 9'd256;
      motion_q       <= 1'b1;
      parity_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_WIDTH:     row_width_q    <= cfg_data_i[12:0];
        CFG_SHIFT_PIXELS:  shift_pixels_q <= cfg_data_i[5:0];
        CFG_BAND_ROWS:     band_rows_q    <= cfg_data_i[2:0];
        CFG_DARKEN_AMOUNT: darken_q       <= cfg_data_i[8:0];
        CFG_MIX_AMOUNT:    mix_q          <= cfg_data_i[8:0];
        CFG_MOTION_ENABLE: motion_q       <= cfg_data_i[0];
        CFG_FRAME_PARITY:  parity_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturation of width, shift and band size.
  always_comb begin
    if (row_width_q == 13'd0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(row_width_q);
    end
    s_sat = (32'(shift_pixels_q) > 32'(SHIFT_LIMIT)) ? 6'(SHIFT_LIMIT) : shift_pixels_q;
    if (band_rows_q == 3'd0) begin
      b_eff = 3'd1;
    end else if (32'(band_rows_q) > 32'(BAND_LIMIT)) begin
      b_eff = 3'(BAND_LIMIT);
    end else begin
      b_eff = band_rows_q;
    end
  end

  // Shift wrap: reload after a write, then subtract the width until it fits.
  assign s_rem_ext    = WEFF_W'(s_rem_q);
  assign wrap_pending = (s_rem_ext >= w_eff);

  always_comb begin
    reload_d = cfg_we_i;
    s_rem_d  = s_rem_q;
    if (reload_q) begin
      s_rem_d = s_sat;
    end else if (wrap_pending) begin
      s_rem_d = 6'(s_rem_ext - w_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= 1'b0;
      s_rem_q  <= 6'd6;
    end else begin
      reload_q <= reload_d;
      s_rem_q  <= s_rem_d;
    end
  end

  // Bundle for the front and the back.
  always_comb begin
    cfg_o.w_eff = w_eff;
    cfg_o.s_eff = s_rem_q;
    cfg_o.b_eff = b_eff;
    cfg_o.keep  = 9'(Q8_ONE) - ((32'(darken_q) > 32'(Q8_ONE)) ? 9'(Q8_ONE) : darken_q);
    cfg_o.mix   = (32'(mix_q) > 32'(Q8_ONE)) ? 9'(Q8_ONE) : mix_q;
    cfg_o.phase = motion_q & parity_q;
    cfg_o.busy  = reload_q | cfg_we_i | wrap_pending;
  end

endmodule

`default_nettype wire

### rtl/core/ilc_front.sv
// ----------------------------------------------------------------------------
// ilc_front: pixel intake
// Tracks column, band row and field, writes each pixel into the line store
// and queues the run of outputs that the pixel releases.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_front
  import ilc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire in_pix_t           in_data_i,
  output logic                   in_stall_o,
  input  wire cfg_t              cfg_i,
  input  wire logic              back_empty_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output cmd_t                   cmd_o,
  output logic                   mem_we_o,
  output logic [ADDR_W-1:0]      mem_addr_o,
  output logic [31:0]            mem_wdata_o
);

  logic [ADDR_W-1:0] col_cnt_q, col_cnt_d;
  logic [1:0]        brc_q, brc_d;
  logic              oddf_q, oddf_d;
  logic              drain_q, drain_d;

  logic              accept;
  logic [ADDR_W-1:0] col_base, col, wm1, s_ext;
  logic [1:0]        brc_base;
  logic              oddf_base;
  logic              row_end;
  logic [2:0]        brc_inc;

  // A new row or a new frame waits until the back has read the old one.
  assign in_stall_o = cfg_i.busy | q_full_i |
                      ((drain_q | in_data_i.start_of_frame) & ~back_empty_i);
  assign accept = in_valid_i & ~in_stall_o;

  // Position of this pixel.
  always_comb begin
    col_base  = in_data_i.start_of_frame ? '0 : col_cnt_q;
    brc_base  = in_data_i.start_of_frame ? '0 : brc_q;
    oddf_base = in_data_i.start_of_frame ? 1'b0 : oddf_q;
    wm1       = ADDR_W'(cfg_i.w_eff - WEFF_W'(1));
    s_ext     = ADDR_W'(cfg_i.s_eff);
    col       = (col_base > wm1) ? wm1 : col_base;
    row_end   = (col == wm1);
    brc_inc   = 3'(brc_base) + 3'd1;
  end

  // Line store write.
  assign mem_we_o    = accept;
  assign mem_addr_o  = col;
  assign mem_wdata_o = {in_data_i.pix_alpha, in_data_i.pix_blue,
                        in_data_i.pix_green, in_data_i.pix_red};

  // Run of outputs released by this pixel.
  always_comb begin
    cmd_o.odd = oddf_base ^ cfg_i.phase;
    if (row_end) begin
      cmd_o.x   = wm1 - s_ext;
      cmd_o.cnt = cfg_i.s_eff;
      push_o    = accept;
    end else begin
      cmd_o.x   = col - s_ext;
      cmd_o.cnt = '0;
      push_o    = accept & (col >= s_ext);
    end
  end

  // Counter updates.
  always_comb begin
    col_cnt_d = col_cnt_q;
    brc_d     = brc_q;
    oddf_d    = oddf_q;
    drain_d   = drain_q & ~back_empty_i;
    if (accept) begin
      if (row_end) begin
        col_cnt_d = '0;
        drain_d   = 1'b1;
        if (brc_inc >= cfg_i.b_eff) begin
          brc_d  = '0;
          oddf_d = ~oddf_base;
        end else begin
          brc_d  = brc_inc[1:0];
          oddf_d = oddf_base;
        end
      end else begin
        col_cnt_d = col + ADDR_W'(1);
        brc_d     = brc_base;
        oddf_d    = oddf_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      brc_q     <= '0;
      oddf_q    <= 1'b0;
      drain_q   <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      brc_q     <= brc_d;
      oddf_q    <= oddf_d;
      drain_q   <= drain_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ilc_queue.sv
// ----------------------------------------------------------------------------
// ilc_queue: command queue
// A short register FIFO that decouples pixel intake from output generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_queue
  import ilc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/ilc_back.sv
// ----------------------------------------------------------------------------
// ilc_back: output generation
// Walks each queued run one column per cycle unless stalled, reads the current
// and shifted pixel and blends odd-field colors in a two-stage multiply pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_back
  import ilc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              q_empty_i,
  input  wire cmd_t              q_head_i,
  output logic                   pop_o,
  output logic                   back_empty_o,
  output logic                   rd_en_o,
  output logic [ADDR_W-1:0]      rd_addr_cur_o,
  output logic [ADDR_W-1:0]      rd_addr_src_o,
  input  wire logic [31:0]       rd_cur_i,
  input  wire logic [31:0]       rd_src_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_pix_t               out_data_o
);

  // Run walker.
  logic              active_q, active_d;
  logic [ADDR_W-1:0] cur_x_q, cur_x_d;
  logic [5:0]        rem_q, rem_d;
  logic              odd_q, odd_d;

  logic              en, head_valid, issue, issue_last;
  logic [ADDR_W-1:0] head_x;
  logic [5:0]        head_rem;
  logic              head_odd;
  logic [WEFF_W-1:0] src_sum;

  // Read stage.
  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_x_q;
  logic              s1_last_q, s1_odd_q;

  // Product stage.
  logic              s2_valid_q;
  logic [ADDR_W-1:0] s2_x_q;
  logic              s2_last_q, s2_odd_q;
  logic [7:0]        s2_c_q [3];
  logic [16:0]       s2_orig_q [3];
  logic [16:0]       s2_shift_q [3];
  logic [7:0]        s2_alpha_q;

  // Output register.
  logic              out_valid_q;
  out_pix_t          out_q;

  logic [8:0]        inv_mix;
  logic [26:0]       acc [3];
  logic [7:0]        blended [3];

  // The whole pipe moves when the output register can take a result.
  assign en = ~out_valid_q | ~out_stall_i;

  always_comb begin
    head_x     = active_q ? cur_x_q : q_head_i.x;
    head_rem   = active_q ? rem_q : q_head_i.cnt;
    head_odd   = active_q ? odd_q : q_head_i.odd;
    head_valid = active_q | ~q_empty_i;
    issue      = en & head_valid;
    issue_last = (head_rem == '0);
    pop_o      = issue & ~active_q;
  end

  assign back_empty_o = q_empty_i & ~active_q;

  // Shifted source column, wrapped into the row.
  always_comb begin
    src_sum = WEFF_W'(head_x) + WEFF_W'(cfg_i.s_eff);
    if (src_sum >= cfg_i.w_eff) begin
      src_sum = src_sum - cfg_i.w_eff;
    end
  end

  assign rd_en_o       = issue;
  assign rd_addr_cur_o = head_x;
  assign rd_addr_src_o = src_sum[ADDR_W-1:0];

  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    rem_d    = rem_q;
    odd_d    = odd_q;
    if (issue) begin
      active_d = ~issue_last;
      cur_x_d  = head_x + ADDR_W'(1);
      rem_d    = head_rem - 6'd1;
      odd_d    = head_odd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    rem_q   <= rem_d;
    odd_q   <= odd_d;
  end

  // Pipe valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Read stage tags; the line store delivers the pixels alongside.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q    <= head_x;
      s1_last_q <= issue_last;
      s1_odd_q  <= head_odd;
    end
  end

  assign inv_mix = 9'(Q8_ONE) - cfg_i.mix;

  // Product stage: original times inverse mix, shifted times keep.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q     <= s1_x_q;
      s2_last_q  <= s1_last_q;
      s2_odd_q   <= s1_odd_q;
      s2_alpha_q <= rd_cur_i[31:24];
      for (int ch = 0; ch < 3; ch++) begin
        s2_c_q[ch]     <= rd_cur_i[8*ch +: 8];
        s2_orig_q[ch]  <= 17'(rd_cur_i[8*ch +: 8]) * 17'(inv_mix);
        s2_shift_q[ch] <= 17'(rd_src_i[8*ch +: 8]) * 17'(cfg_i.keep);
      end
    end
  end

  // Blend, round half up and clamp.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = {2'b00, s2_orig_q[ch], 8'h00}
              + (27'(s2_shift_q[ch]) * 27'(cfg_i.mix))
              + 27'(ROUND_HALF);
      blended[ch] = (acc[ch][26:16] > 11'd255) ? 8'hFF : acc[ch][23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_red     <= s2_odd_q ? blended[0] : s2_c_q[0];
      out_q.out_green   <= s2_odd_q ? blended[1] : s2_c_q[1];
      out_q.out_blue    <= s2_odd_q ? blended[2] : s2_c_q[2];
      out_q.out_alpha   <= s2_alpha_q;
      out_q.out_column  <= 12'(s2_x_q);
      out_q.last_of_run <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/interlace_comb_pixel.sv
// Throughput: one pixel per cycle inside a row while the output is not stalled. The last
// pixel of a row releases a burst of shift+1 results; the next row's first pixel waits
// until the burst has been read from the line store. Start of frame waits the same way,
// and a configuration write holds input while the shift is wrapped.
// Reset clears counters, queue and pipe; the line store is not cleared.
// ----------------------------------------------------------------------------
// interlace_comb_pixel: interlace comb effect on an RGBA pixel stream
// A front stores pixels and queues output runs, a back reads the line store
// and blends odd-field rows with a horizontally shifted copy.
// ----------------------------------------------------------------------------
`default_nettype none

module interlace_comb_pixel
  import ilc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_pix_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_pix_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg;
  logic              push, pop, q_empty, q_full, back_empty;
  cmd_t              push_cmd, head_cmd;
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] mem_addr, rd_addr_cur, rd_addr_src;
  logic [31:0]       mem_wdata, rd_cur, rd_src;

  // Configuration registers.
  ilc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Pixel intake.
  ilc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .cfg_i        (cfg),
    .back_empty_i (back_empty),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata)
  );

  // Command queue.
  ilc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Line store.
  ilc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_addr),
    .wdata_i   (mem_wdata),
    .re_i      (rd_en),
    .raddr_a_i (rd_addr_cur),
    .raddr_b_i (rd_addr_src),
    .rdata_a_o (rd_cur),
    .rdata_b_o (rd_src)
  );

  // Output generation.
  ilc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_head_i      (head_cmd),
    .pop_o         (pop),
    .back_empty_o  (back_empty),
    .rd_en_o       (rd_en),
    .rd_addr_cur_o (rd_addr_cur),
    .rd_addr_src_o (rd_addr_src),
    .rd_cur_i      (rd_cur),
    .rd_src_i      (rd_src),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire
